// ===== design/lph_pkg.sv =====
// Shared constants for the linear-probe hash table.
// No dependencies; used by the interfaces and the top level.
`default_nettype none
package lph_pkg;

  // Fixed field widths of the transactions
  localparam int KEY_W  = 16;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 2;

  // Request opcodes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  // Response status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

endpackage
`default_nettype wire

// ===== design/lph_req_if.sv =====
// Request channel: valid/ready handshake carrying mode and key.
// Depends on lph_pkg for field widths.
`default_nettype none
interface lph_req_if;
  logic                       valid;
  logic                       ready;
  logic [lph_pkg::MODE_W-1:0] mode;
  logic [lph_pkg::KEY_W-1:0]  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface
`default_nettype wire

// ===== design/lph_rsp_if.sv =====
// Response channel: valid/ready handshake carrying slot_index and status.
// Depends on lph_pkg for field widths.
`default_nettype none
interface lph_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [lph_pkg::IDX_W-1:0]  slot_index;
  logic [lph_pkg::STAT_W-1:0] status;

  modport source (output valid, output slot_index, output status, input ready);
  modport sink   (input valid, input slot_index, input status, output ready);
endinterface
`default_nettype wire

// ===== design/linear_probe_hash_table.sv =====
// Linear-probe hash table: open addressing over TABLE_SIZE slots held in one
// synchronous RAM (valid bit + key per slot). Depends on lph_pkg, lph_req_if,
// lph_rsp_if, lph_ram and lph_mod.
//
// One request is processed at a time; one response per request. After reset
// a clearing sweep writes every slot empty, during which no request is taken.
// Clear requests run the same sweep. Insert and search first compute the home
// slot with a reciprocal-multiply remainder unit, then probe one slot per cycle
// through the RAM read port. Opcode 3 is answered directly, without a probe.
// The response sits in an output register, so a new request is taken while it
// waits to drain.
`default_nettype none
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 16,
  parameter int KEY_BITS   = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  lph_req_if.sink   req,
  lph_rsp_if.source rsp
);
  // Effective key width: the port is 16 bits, KEY_BITS may mask it further
  localparam int KW = (KEY_BITS < lph_pkg::KEY_W) ? KEY_BITS : lph_pkg::KEY_W;
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int XW = (IW > lph_pkg::IDX_W) ? IW : lph_pkg::IDX_W;
  localparam int RW = KW + 1;  // {valid, key}

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  // Captured request
  logic [lph_pkg::MODE_W-1:0] mode_q;
  logic [KW-1:0]              key_q;
  logic                       pending;   // a transaction is in flight

  // Probe bookkeeping
  logic [IW-1:0] ptr;       // slot being read (or swept)
  logic [IW-1:0] chk_ptr;   // slot whose data is on rdata
  logic          chk;       // rdata is valid this cycle
  logic [IW-1:0] cnt;       // slots already checked
  logic [IW-1:0] ptr_inc;

  // Result staging
  logic [IW-1:0]              res_idx;
  logic [lph_pkg::STAT_W-1:0] res_st;
  logic [XW-1:0]              res_ext;

  // RAM port
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic          slot_v;
  logic [KW-1:0] slot_k;

  // Remainder unit
  logic          mod_start;
  logic          mod_done;
  logic [IW-1:0] mod_home;

  logic out_valid;
  logic out_load;

  assign ptr_inc = (ptr == IW'(TABLE_SIZE - 1)) ? '0 : ptr + IW'(1);
  assign slot_v  = ram_rdata[KW];
  assign slot_k  = ram_rdata[KW-1:0];
  assign res_ext = XW'(res_idx);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  assign mod_start = req.valid && req.ready &&
                     (req.mode == lph_pkg::MODE_INSERT || req.mode == lph_pkg::MODE_SEARCH);

  lph_mod #(
    .TABLE_SIZE (TABLE_SIZE),
    .KW         (KW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   (req.key[KW-1:0]),
    .done  (mod_done),
    .home  (mod_home)
  );

  lph_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  // RAM writes: empty words during a sweep, the new key on an insert hit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    if (state == S_SWEEP) begin
      ram_we = 1'b1;
    end else if (state == S_PROBE && chk && !slot_v && mode_q == lph_pkg::MODE_INSERT) begin
      ram_we    = 1'b1;
      ram_waddr = chk_ptr;
      ram_wdata = {1'b1, key_q};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      chk       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_SWEEP: begin
          if (ptr == IW'(TABLE_SIZE - 1)) begin
            state <= pending ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            pending <= 1'b1;
            case (req.mode)
              lph_pkg::MODE_CLEAR:  state <= S_SWEEP;
              lph_pkg::MODE_INSERT,
              lph_pkg::MODE_SEARCH: state <= S_HASH;
              default:              state <= S_DONE;
            endcase
          end
        end
        S_HASH: begin
          chk <= 1'b0;
          if (mod_done) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          chk <= 1'b1;
          if (chk) begin
            if (!slot_v || (mode_q == lph_pkg::MODE_SEARCH && slot_k == key_q) ||
                cnt == IW'(TABLE_SIZE - 1)) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            pending <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; the sweep pointer starts at slot 0 after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      case (state)
        S_SWEEP: begin
          ptr     <= ptr_inc;
          res_idx <= '0;
          res_st  <= lph_pkg::STAT_OK;
        end
        S_IDLE: begin
          ptr     <= '0;
          mode_q  <= req.mode;
          key_q   <= req.key[KW-1:0];
          res_idx <= '0;
          res_st  <= lph_pkg::STAT_OK;
        end
        S_HASH: begin
          ptr <= mod_home;
          cnt <= '0;
        end
        S_PROBE: begin
          ptr     <= ptr_inc;
          chk_ptr <= ptr;
          if (chk) begin
            cnt <= cnt + IW'(1);
            if (!slot_v) begin
              // empty slot: insert lands here, search ends here
              if (mode_q == lph_pkg::MODE_INSERT) begin
                res_idx <= chk_ptr;
                res_st  <= lph_pkg::STAT_OK;
              end else begin
                res_idx <= '0;
                res_st  <= lph_pkg::STAT_NOT_FOUND;
              end
            end else if (mode_q == lph_pkg::MODE_SEARCH && slot_k == key_q) begin
              res_idx <= chk_ptr;
              res_st  <= lph_pkg::STAT_OK;
            end else begin
              // full round with no hit
              res_idx <= '0;
              res_st  <= (mode_q == lph_pkg::MODE_INSERT) ? lph_pkg::STAT_FULL
                                                         : lph_pkg::STAT_NOT_FOUND;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.slot_index <= res_ext[lph_pkg::IDX_W-1:0];
      rsp.status     <= res_st;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // An accepted request always moves the sequencer out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // Keys are only written into the table by an insert probe
  a_key_write_insert: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_wdata[KW]) |-> (state == S_PROBE && mode_q == lph_pkg::MODE_INSERT))
    else $error("occupied slot written outside an insert");

  // Failure responses carry slot index zero
  a_fail_zero_index: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != lph_pkg::STAT_OK) |-> (rsp.slot_index == '0))
    else $error("failure response with nonzero slot index");

  // No response is produced while no transaction is in flight
  a_load_pending: assert property (@(posedge clk) disable iff (rst)
    out_load |-> pending)
    else $error("response loaded with no transaction in flight");

endmodule
`default_nettype wire

// ===== design/lph_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/lph_mod.sv =====
// Home slot unit: key mod TABLE_SIZE by reciprocal multiplication.
// Registered steps from start to done: multiply and shift, then multiply back and subtract.
// No package dependencies.
`default_nettype none
module lph_mod #(
  parameter int TABLE_SIZE = 16,
  parameter int KW         = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [KW-1:0]                 key,
  output      logic                          done,
  output      logic [$clog2(TABLE_SIZE)-1:0] home
);
  localparam int IW = $clog2(TABLE_SIZE);
  // quotient = (key * RECIP) >> SH, exact for every KW-bit key
  localparam int     SH    = KW + IW;
  localparam int     PW    = SH + KW + 2;
  localparam int     BW    = KW + IW;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(TABLE_SIZE) - longint'(1)) /
                             longint'(TABLE_SIZE);

  logic [PW-1:0] prod;
  logic [KW-1:0] quot;
  logic [KW-1:0] key_r;
  logic [BW-1:0] back;
  logic [BW-1:0] rem_w;
  logic          busy;

  assign prod  = PW'(key) * PW'(RECIP);
  assign back  = BW'(quot) * BW'(TABLE_SIZE);
  assign rem_w = BW'(key_r) - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
      quot  <= prod[SH +: KW];
    end
    if (busy) begin
      home <= rem_w[IW-1:0];
    end
  end
endmodule
`default_nettype wire
